// File: hw/rtl/psgmix_pkg.sv
// shared types, constants and helpers for the six-channel mixer
package psgmix_pkg;

	localparam int NUM_CHAN  = 6;
	localparam int SAMPLE_W  = 8;
	localparam int VOL_W     = 8;
	localparam int NIBBLE_W  = 4;
	localparam int GAIN_W    = 5;
	localparam int PROD_W    = 13;
	localparam int LEVEL_W   = 16;

	localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hF;
	localparam logic signed [LEVEL_W:0] SAT_MAX = 17'sd32767;
	localparam logic signed [LEVEL_W:0] SAT_MIN = -17'sd32768;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [VOL_W-1:0]           vol_t;
	typedef logic [GAIN_W-1:0]          gain_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [LEVEL_W-1:0]  level_t;

	// control that travels beside the lane products
	typedef struct packed {
		logic valid;
		logic block_end;
	} lane_ctrl_t;

	// left nibble plus right nibble
	function automatic gain_t gain_of(input vol_t vol);
		gain_t lo;
		gain_t hi;
		lo = {1'b0, vol[NIBBLE_W-1:0] & NIBBLE_MASK};
		hi = {1'b0, vol[VOL_W-1:NIBBLE_W] & NIBBLE_MASK};
		return gain_t'(lo + hi);
	endfunction

endpackage

// File: hw/rtl/psgmix_in_if.sv
// input channel: one frame of six channel samples and the block end flag
interface psgmix_in_if;
	logic                 valid;
	logic                 ready;
	psgmix_pkg::sample_t  chan0_sample;
	psgmix_pkg::sample_t  chan1_sample;
	psgmix_pkg::sample_t  chan2_sample;
	psgmix_pkg::sample_t  chan3_sample;
	psgmix_pkg::sample_t  chan4_sample;
	psgmix_pkg::sample_t  chan5_sample;
	logic                 block_end_in;

	modport source (
		output valid, chan0_sample, chan1_sample, chan2_sample,
		chan3_sample, chan4_sample, chan5_sample, block_end_in,
		input  ready
	);
	modport sink (
		input  valid, chan0_sample, chan1_sample, chan2_sample,
		chan3_sample, chan4_sample, chan5_sample, block_end_in,
		output ready
	);
endinterface

// File: hw/rtl/psgmix_out_if.sv
// output channel: filtered mono sample and the block end flag
interface psgmix_out_if;
	logic                valid;
	logic                ready;
	psgmix_pkg::level_t  mixed_sample;
	logic                block_end_out;

	modport source (output valid, mixed_sample, block_end_out, input ready);
	modport sink (input valid, mixed_sample, block_end_out, output ready);
endinterface

// File: hw/rtl/psgmix_cfg_if.sv
// configuration write channel for the master volume register
interface psgmix_cfg_if;
	logic              valid;
	logic              ready;
	psgmix_pkg::vol_t  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/psg_six_channel_mix_lowpass.sv
// top level: six-channel mixer with master gain and two one-pole low-pass stages
// throughput: one frame per cycle while the output sink keeps ready high; lane multiply,
// merge tree, stage one and stage two each own one register stage, and each stage
// frees as soon as the next takes it
// reset clears pipeline valids, both filter levels and the master volume to zero
module psg_six_channel_mix_lowpass (
	input  logic         clk,
	input  logic         arst_n,
	psgmix_cfg_if.sink   cfg,
	psgmix_in_if.sink    smp_in,
	psgmix_out_if.source smp_out
);
	import psgmix_pkg::*;

	vol_t       vol_q;
	gain_t      gain;
	sample_t    smp [NUM_CHAN];
	prod_t      prod_s1 [NUM_CHAN];
	lane_ctrl_t ctrl_s1;
	logic       vld_s1;
	logic       blk_s1;
	logic       merge_ready;
	logic       in_ready;
	logic       load_s1;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q <= '0;
		end else if (cfg.valid) begin
			vol_q <= cfg.data;
		end
	end

	assign gain = gain_of(vol_q);

	assign smp[0] = smp_in.chan0_sample;
	assign smp[1] = smp_in.chan1_sample;
	assign smp[2] = smp_in.chan2_sample;
	assign smp[3] = smp_in.chan3_sample;
	assign smp[4] = smp_in.chan4_sample;
	assign smp[5] = smp_in.chan5_sample;

	assign in_ready     = !vld_s1 || merge_ready;
	assign smp_in.ready = in_ready;
	assign load_s1      = smp_in.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= smp_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			blk_s1 <= smp_in.block_end_in;
		end
	end

	assign ctrl_s1 = '{valid: vld_s1, block_end: blk_s1};

	for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
		psgmix_lane u_lane (
			.clk     (clk),
			.load    (load_s1),
			.sample  (smp[g]),
			.gain    (gain),
			.prod_s1 (prod_s1[g])
		);
	end

	psgmix_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.prod_s1  (prod_s1),
		.ctrl_s1  (ctrl_s1),
		.ready_s1 (merge_ready),
		.smp_out  (smp_out)
	);
endmodule

// File: hw/rtl/psgmix_lane.sv
// one channel lane: sample times master gain, registered
module psgmix_lane (
	input  logic                clk,
	input  logic                load,
	input  psgmix_pkg::sample_t sample,
	input  psgmix_pkg::gain_t   gain,
	output psgmix_pkg::prod_t   prod_s1
);
	import psgmix_pkg::*;

	logic signed [SAMPLE_W+GAIN_W:0] prod_full;

	assign prod_full = sample * $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= prod_full[PROD_W-1:0];
		end
	end
endmodule

// File: hw/rtl/psgmix_merge.sv
// merges lane products, runs the two one-pole stages and holds the output
module psgmix_merge (
	input  logic                   clk,
	input  logic                   arst_n,
	input  psgmix_pkg::prod_t      prod_s1 [psgmix_pkg::NUM_CHAN],
	input  psgmix_pkg::lane_ctrl_t ctrl_s1,
	output logic                   ready_s1,
	psgmix_out_if.source           smp_out
);
	import psgmix_pkg::*;

	logic   v_s2, v_s3, v_s4;
	logic   blk_s2, blk_s3, blk_s4;
	level_t sum_s2;
	level_t lvl1_s3;
	level_t mixed_s4;
	level_t first_q;
	level_t second_q;

	logic   rdy2, rdy3, rdy4;
	logic   ld3, ld4;
	level_t sum_c;
	logic signed [LEVEL_W:0] acc1;
	logic signed [LEVEL_W:0] acc2;
	logic signed [LEVEL_W:0] half2;
	level_t first_c;
	level_t sat_c;

	assign rdy4     = !v_s4 || smp_out.ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign ready_s1 = rdy2;
	assign ld3      = v_s2 && rdy3;
	assign ld4      = v_s3 && rdy4;

	// merge tree over the lanes
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NUM_CHAN; i++) begin
			sum_c = sum_c + LEVEL_W'(prod_s1[i]);
		end
	end

	// each stage is floor((x + level) / 2)
	assign acc1    = {sum_s2[LEVEL_W-1], sum_s2} + {first_q[LEVEL_W-1], first_q};
	assign first_c = acc1[LEVEL_W:1];
	assign acc2    = {lvl1_s3[LEVEL_W-1], lvl1_s3} + {second_q[LEVEL_W-1], second_q};
	assign half2   = acc2 >>> 1;

	always_comb begin
		if (half2 > SAT_MAX) begin
			sat_c = SAT_MAX[LEVEL_W-1:0];
		end else if (half2 < SAT_MIN) begin
			sat_c = SAT_MIN[LEVEL_W-1:0];
		end else begin
			sat_c = half2[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			first_q  <= '0;
			second_q <= '0;
		end else begin
			if (rdy2) begin
				v_s2 <= ctrl_s1.valid;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (ld3) begin
				first_q <= first_c;
			end
			if (ld4) begin
				second_q <= sat_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid && rdy2) begin
			sum_s2 <= sum_c;
			blk_s2 <= ctrl_s1.block_end;
		end
		if (ld3) begin
			lvl1_s3 <= first_c;
			blk_s3  <= blk_s2;
		end
		if (ld4) begin
			mixed_s4 <= sat_c;
			blk_s4   <= blk_s3;
		end
	end

	assign smp_out.valid         = v_s4;
	assign smp_out.mixed_sample  = mixed_s4;
	assign smp_out.block_end_out = blk_s4;

	a_out_matches_level: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> mixed_s4 == second_q)
		else $error("output sample differs from second stage level");

	a_first_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!ld3 |=> $stable(first_q))
		else $error("first stage level moved without a transaction");

	a_second_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!ld4 |=> $stable(second_q))
		else $error("second stage level moved without a transaction");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rdy2 |-> (v_s2 && v_s3 && v_s4 && !smp_out.ready))
		else $error("pipeline stalled with a free stage");
endmodule

// File: sim/testbench.sv
// testbench for the six-channel mixer with master gain and two low-pass stages
`timescale 1ns / 100ps

module testbench;
	import psgmix_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 7;
	localparam int PIPE_LATENCY = 4;
	localparam int PHASE_ITEMS  = 225;
	localparam int NUM_PHASES   = 8;
	localparam int IDLE_PCT     = 12;
	localparam int HOLD_CYCLES  = 80;
	localparam int CYCLE_LIMIT  = 200000;

	localparam vol_t VOL_SILENT = 8'h00;
	localparam vol_t VOL_FULL   = 8'hFF;

	localparam sample_t SMP_MAX = 8'sd127;
	localparam sample_t SMP_MIN = -8'sd128;

	typedef struct packed {
		sample_t [NUM_CHAN-1:0] chan;
		logic                   block_end;
	} frame_t;

	typedef struct {
		level_t sample;
		logic   block_end;
	} mono_out_t;

	// tracks the master volume and both filter levels, queues the samples due
	class lowpass_mix_tracker;
		vol_t      master_vol;
		int        lp1_level;
		int        lp2_level;
		int        errors;
		mono_out_t due_samples[$];

		function new();
			master_vol = VOL_SILENT;
			lp1_level  = 0;
			lp2_level  = 0;
			errors     = 0;
		endfunction

		function void set_volume(vol_t v);
			master_vol = v;
		endfunction

		function int pending();
			return due_samples.size();
		endfunction

		// one input transaction: mix, scale, filter twice, saturate
		function void take_frame(frame_t f);
			int mix;
			int gain;
			int y;
			mono_out_t item;
			mix = 0;
			for (int i = 0; i < NUM_CHAN; i++)
				mix += int'(sample_t'(f.chan[i]));
			gain = int'(master_vol[7:4]) + int'(master_vol[3:0]);
			mix = mix * gain;
			lp1_level = (mix + lp1_level) >>> 1;
			lp2_level = (lp1_level + lp2_level) >>> 1;
			y = lp2_level;
			if (y > 32767)
				y = 32767;
			if (y < -32768)
				y = -32768;
			item.sample    = level_t'(y);
			item.block_end = f.block_end;
			due_samples.push_back(item);
		endfunction

		function void check_sample(level_t sample, logic block_end);
			mono_out_t want;
			if (due_samples.size() == 0) begin
				$display("%0t: unexpected output sample %0d block_end %0b",
					$time, sample, block_end);
				errors++;
				return;
			end
			want = due_samples.pop_front();
			if (sample !== want.sample) begin
				$display("%0t: mixed_sample expected %0d actual %0d",
					$time, want.sample, sample);
				errors++;
			end
			if (block_end !== want.block_end) begin
				$display("%0t: block_end_out expected %0b actual %0b",
					$time, want.block_end, block_end);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	bit   steady;
	bit   hold_off_req;
	int   hold_left;

	lowpass_mix_tracker tracker;

	psgmix_cfg_if cfg_bus ();
	psgmix_in_if  in_bus ();
	psgmix_out_if out_bus ();

	psg_six_channel_mix_lowpass u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.smp_in  (in_bus),
		.smp_out (out_bus)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("** psg_six_channel_mix_lowpass: FAILED **");
		$finish;
	end

	// output side: check each transaction, then decide ready for the next cycle
	initial begin
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_bus.valid && out_bus.ready)
				tracker.check_sample(out_bus.mixed_sample, out_bus.block_end_out);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	function automatic frame_t uniform_frame(sample_t v, logic block_end);
		frame_t f;
		for (int i = 0; i < NUM_CHAN; i++)
			f.chan[i] = v;
		f.block_end = block_end;
		return f;
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int pick;
		pick = $urandom_range(19);
		for (int i = 0; i < NUM_CHAN; i++)
			f.chan[i] = sample_t'($urandom_range(255));
		// occasional frames at the extremes push the levels toward full scale
		if (pick == 0)
			f = uniform_frame(SMP_MAX, 1'b0);
		else if (pick == 1)
			f = uniform_frame(SMP_MIN, 1'b0);
		f.block_end = ($urandom_range(7) == 0);
		return f;
	endfunction

	task automatic send_frame(frame_t f);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid        <= 1'b1;
		in_bus.chan0_sample <= f.chan[0];
		in_bus.chan1_sample <= f.chan[1];
		in_bus.chan2_sample <= f.chan[2];
		in_bus.chan3_sample <= f.chan[3];
		in_bus.chan4_sample <= f.chan[4];
		in_bus.chan5_sample <= f.chan[5];
		in_bus.block_end_in <= f.block_end;
		do
			@(posedge clk);
		while (!in_bus.ready);
		tracker.take_frame(f);
	endtask

	// stop offering and let every due sample come out before going on
	task automatic settle();
		in_bus.valid <= 1'b0;
		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_volume(vol_t v);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= v;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		tracker.set_volume(v);
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin
		frame_t f;
		vol_t   vol;
		tracker = new();
		cycle_count = 0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		arst_n <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.data  <= VOL_SILENT;
		in_bus.valid  <= 1'b0;
		in_bus.chan0_sample <= '0;
		in_bus.chan1_sample <= '0;
		in_bus.chan2_sample <= '0;
		in_bus.chan3_sample <= '0;
		in_bus.chan4_sample <= '0;
		in_bus.chan5_sample <= '0;
		in_bus.block_end_in <= 1'b0;
		out_bus.ready <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full gain: drive the levels toward their positive and negative extremes
		write_volume(VOL_FULL);
		repeat (3) send_frame(uniform_frame(SMP_MAX, 1'b0));
		repeat (3) send_frame(uniform_frame(SMP_MIN, 1'b1));
		send_frame(uniform_frame(8'sd0, 1'b0));
		send_frame(uniform_frame(8'sh55, 1'b1));
		send_frame(uniform_frame(sample_t'(8'hAA), 1'b0));
		for (int k = 0; k < NUM_CHAN; k++) begin
			f = uniform_frame(SMP_MIN, k[0]);
			f.chan[k] = SMP_MAX;
			send_frame(f);
		end
		settle();

		// zero gain: filter input is silent, output decays
		write_volume(VOL_SILENT);
		repeat (5) send_frame(random_frame());

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: vol = 8'h0F;
				1: vol = 8'hF0;
				2: vol = 8'h88;
				4: vol = VOL_FULL;
				5: vol = 8'h01;
				7: vol = VOL_SILENT;
				default: vol = vol_t'($urandom_range(255));
			endcase
			write_volume(vol);
			steady = (p == 3);
			if (p == 5)
				hold_off_req = 1'b1;
			repeat (PHASE_ITEMS) send_frame(random_frame());
		end
		steady = 1'b0;
		settle();
		repeat (2 * PIPE_LATENCY) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("** psg_six_channel_mix_lowpass: PASSED **");
		else
			$display("** psg_six_channel_mix_lowpass: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/psgmix_pkg.sv
hw/rtl/psgmix_in_if.sv
hw/rtl/psgmix_out_if.sv
hw/rtl/psgmix_cfg_if.sv
hw/rtl/psgmix_lane.sv
hw/rtl/psgmix_merge.sv
hw/rtl/psg_six_channel_mix_lowpass.sv
sim/testbench.sv
